// ----- sv/pfarc_pkg.sv -----
// Types, codes and constants of the reference-counted page-frame allocator.
package pfarc_pkg;

    localparam int PAGES_DEFAULT = 1024;

    // One word of the used-page bitmap covers this many pages.
    localparam int ROW_W  = 32;
    localparam int BIT_AW = 5;

    localparam logic [31:0] FRAME_MASK = 32'hffff_f000;
    localparam int          PAGE_SHIFT = 12;
    localparam logic [31:0] WRITABLE_BIT = 32'h0000_0002;
    localparam logic [31:0] NEW_PAGE_FLAGS = 32'h0000_0007;

    localparam logic [31:0] BASE_RESET     = 32'h0000_0000;
    localparam logic [10:0] TOTAL_RESET    = 11'd1024;
    localparam logic [10:0] RESERVED_RESET = 11'd0;

    typedef enum logic [1:0] {
        CFG_BASE     = 2'd0,
        CFG_TOTAL    = 2'd1,
        CFG_RESERVED = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_COW   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_NO_FREE      = 3'd1,
        STS_ALREADY_FREE = 3'd2,
        STS_OUT_OF_RANGE = 3'd3,
        STS_WRITABLE     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_COUNT,
        S_CLEAR,
        S_FIND,
        S_PICK,
        S_DEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] page_word;
    } pfarc_in_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic [2:0]  status;
    } pfarc_out_t;

endpackage

// ----- sv/page_frame_allocator_refcount_unit.sv -----
// Top level of the reference-counted page-frame allocator.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      pfarc_in_t  (operation, page_word)
//   m_       out        m_valid / m_ready      pfarc_out_t (result_word, status)
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. Allocate scans the full-row summary one 32-row group at a
// time (1 group at 1024 pages) and then picks a page from the first row found;
// free decodes, reads the count and may clear a bitmap bit, and copy-on-write may
// scan the groups as allocate does. Initialize rewrites every count, one entry a
// cycle. After reset the same sweep clears the counts, with s_ready low.
// A result waits in the output register; the next item is taken meanwhile and
// its own result holds until the output register is free.
module page_frame_allocator_refcount_unit #(
    parameter int PAGES = pfarc_pkg::PAGES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pfarc_pkg::pfarc_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfarc_pkg::pfarc_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int ROW_W  = pfarc_pkg::ROW_W;
    localparam int BIT_AW = pfarc_pkg::BIT_AW;
    localparam int IDX_AW = $clog2(PAGES);
    localparam int MW     = IDX_AW + 1;
    localparam int ROWS   = (PAGES + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIW    = ROW_AW + BIT_AW;
    localparam int NGRP   = (ROWS + ROW_W - 1) / ROW_W;
    localparam int GRP_AW = (NGRP > 1) ? $clog2(NGRP) : 1;

    // Use counts, and one bit per page that is set while its count is nonzero.
    logic [7:0]       cnt_mem [PAGES];
    logic [ROW_W-1:0] bmp_mem [ROWS];

    logic [7:0]       cnt_rdata_reg;
    logic [ROW_W-1:0] bmp_rdata_reg;

    logic              cnt_we, bmp_we;
    logic [IDX_AW-1:0] cnt_addr;
    logic [7:0]        cnt_wdata;
    logic [ROW_AW-1:0] bmp_addr;
    logic [ROW_W-1:0]  bmp_wdata;

    pfarc_pkg::state_t state_reg, state_next;

    logic [31:0] cfg_base_reg;
    logic [10:0] cfg_total_reg, cfg_reserved_reg;

    logic [1:0]        op_reg, op_next;
    logic [31:0]       word_reg, word_next;
    logic [7:0]        before_reg, before_next;
    logic [IDX_AW-1:0] idx_old_reg, idx_old_next;
    logic              managed_old_reg, managed_old_next;
    logic [GRP_AW-1:0] grp_reg, grp_next;
    logic [ROW_AW-1:0] pick_row_reg, pick_row_next;
    logic [IDX_AW-1:0] sw_reg, sw_next;
    logic [10:0]       sw_limit_reg, sw_limit_next;
    logic              sw_reply_reg, sw_reply_next;
    logic [31:0]       res_word_reg, res_word_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [ROWS-1:0]   full_reg, full_next;
    logic              m_valid_reg, m_valid_next;
    pfarc_pkg::pfarc_out_t m_data_reg, m_data_next;

    // Address decode of the page word.
    logic [31:0]       base_al;
    logic [31:0]       diff;
    logic [MW-1:0]     mng;
    logic              dec_managed;
    logic [IDX_AW-1:0] dec_idx;

    assign base_al     = cfg_base_reg & pfarc_pkg::FRAME_MASK;
    assign diff        = word_reg - base_al;
    assign mng         = (32'(cfg_total_reg) > 32'(PAGES)) ? MW'(PAGES) : MW'(cfg_total_reg);
    assign dec_managed = (word_reg >= base_al) && (32'(diff[31:12]) < 32'(mng));
    assign dec_idx     = diff[12 +: IDX_AW];

    logic [PIW-1:0]    old_w;
    logic [ROW_AW-1:0] old_row;
    logic [ROW_W-1:0]  old_mask;

    assign old_w    = PIW'(idx_old_reg);
    assign old_row  = old_w[PIW-1:BIT_AW];
    assign old_mask = ROW_W'(1) << old_w[BIT_AW-1:0];

    // Summary of full rows, padded with full groups past the last row.
    logic [NGRP*ROW_W-1:0] full_pad;
    for (genvar k = 0; k < NGRP * ROW_W; k++) begin : g_pad
        if (k < ROWS) begin : g_row
            assign full_pad[k] = full_reg[k];
        end else begin : g_fill
            assign full_pad[k] = 1'b1;
        end
    end

    logic [ROW_W-1:0]  grp_bits;
    logic              find_hit;
    logic [BIT_AW-1:0] find_k;
    logic [ROW_AW-1:0] find_row;

    assign grp_bits = full_pad[grp_reg*ROW_W +: ROW_W];

    always_comb begin
        find_hit = 1'b0;
        find_k   = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (!grp_bits[j]) begin
                find_hit = 1'b1;
                find_k   = BIT_AW'(j);
            end
        end
    end

    assign find_row = ROW_AW'((32'(grp_reg) << BIT_AW) | 32'(find_k));

    // Lowest clear bit of the fetched bitmap row.
    logic              pick_hit;
    logic [BIT_AW-1:0] pick_j;
    logic [31:0]       pick_idx32;
    logic              pick_ok;
    logic [ROW_W-1:0]  pick_row_val;
    logic [31:0]       pick_addr;

    always_comb begin
        pick_hit = 1'b0;
        pick_j   = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (!bmp_rdata_reg[j]) begin
                pick_hit = 1'b1;
                pick_j   = BIT_AW'(j);
            end
        end
    end

    assign pick_idx32   = (32'(pick_row_reg) << BIT_AW) | 32'(pick_j);
    assign pick_ok      = pick_hit && (pick_idx32 < 32'(mng));
    assign pick_row_val = bmp_rdata_reg | (ROW_W'(1) << pick_j);
    assign pick_addr    = base_al + (pick_idx32 << pfarc_pkg::PAGE_SHIFT);

    // Bitmap row written by the initialize sweep.
    logic [PIW-1:0]    sw_w;
    logic [ROW_AW-1:0] sw_row;
    logic [ROW_W-1:0]  sw_row_val;
    logic              sw_last;

    assign sw_w    = PIW'(sw_reg);
    assign sw_row  = sw_w[PIW-1:BIT_AW];
    assign sw_last = (sw_reg == IDX_AW'(PAGES - 1));

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            sw_row_val[j] = ((32'(sw_row) << BIT_AW) | 32'(j)) < 32'(sw_limit_reg);
        end
    end

    assign s_ready   = (state_reg == pfarc_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfarc_pkg::S_SWEEP: begin
                if (sw_last) begin
                    state_next = sw_reply_reg ? pfarc_pkg::S_DONE : pfarc_pkg::S_IDLE;
                end
            end
            pfarc_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_data.operation)
                        pfarc_pkg::OP_INIT:  state_next = pfarc_pkg::S_SWEEP;
                        pfarc_pkg::OP_ALLOC: state_next = pfarc_pkg::S_FIND;
                        default:             state_next = pfarc_pkg::S_DECODE;
                    endcase
                end
            end
            pfarc_pkg::S_DECODE: begin
                if (dec_managed) begin
                    state_next = pfarc_pkg::S_COUNT;
                end else if (op_reg == pfarc_pkg::OP_FREE) begin
                    state_next = pfarc_pkg::S_DONE;
                end else begin
                    state_next = pfarc_pkg::S_FIND;
                end
            end
            pfarc_pkg::S_COUNT: begin
                if (op_reg == pfarc_pkg::OP_FREE) begin
                    state_next = (cnt_rdata_reg == 8'd1) ? pfarc_pkg::S_CLEAR : pfarc_pkg::S_DONE;
                end else begin
                    state_next = (cnt_rdata_reg == 8'd1) ? pfarc_pkg::S_DONE : pfarc_pkg::S_FIND;
                end
            end
            pfarc_pkg::S_CLEAR: state_next = pfarc_pkg::S_DONE;
            pfarc_pkg::S_FIND: begin
                if (find_hit) begin
                    state_next = pfarc_pkg::S_PICK;
                end else if (grp_reg == GRP_AW'(NGRP - 1)) begin
                    state_next = pfarc_pkg::S_DONE;
                end
            end
            pfarc_pkg::S_PICK: begin
                if (pick_ok && op_reg == pfarc_pkg::OP_COW && managed_old_reg
                        && before_reg != 8'd0) begin
                    state_next = pfarc_pkg::S_DEC;
                end else begin
                    state_next = pfarc_pkg::S_DONE;
                end
            end
            pfarc_pkg::S_DEC: state_next = pfarc_pkg::S_DONE;
            pfarc_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pfarc_pkg::S_IDLE;
                end
            end
            default: state_next = pfarc_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory ports and the output register.
    always_comb begin
        op_next          = op_reg;
        word_next        = word_reg;
        before_next      = before_reg;
        idx_old_next     = idx_old_reg;
        managed_old_next = managed_old_reg;
        grp_next         = grp_reg;
        pick_row_next    = pick_row_reg;
        sw_next          = sw_reg;
        sw_limit_next    = sw_limit_reg;
        sw_reply_next    = sw_reply_reg;
        res_word_next    = res_word_reg;
        res_status_next  = res_status_reg;
        full_next        = full_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        cnt_we           = 1'b0;
        cnt_addr         = idx_old_reg;
        cnt_wdata        = before_reg - 8'd1;
        bmp_we           = 1'b0;
        bmp_addr         = old_row;
        bmp_wdata        = bmp_rdata_reg & ~old_mask;

        case (state_reg)
            pfarc_pkg::S_SWEEP: begin
                cnt_we            = 1'b1;
                cnt_addr          = sw_reg;
                cnt_wdata         = (32'(sw_reg) < 32'(sw_limit_reg)) ? 8'd1 : 8'd0;
                bmp_we            = 1'b1;
                bmp_addr          = sw_row;
                bmp_wdata         = sw_row_val;
                full_next[sw_row] = &sw_row_val;
                sw_next           = sw_reg + IDX_AW'(1);
                res_word_next     = '0;
                res_status_next   = pfarc_pkg::STS_OK;
            end
            pfarc_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.operation;
                    word_next     = s_data.page_word;
                    sw_next       = '0;
                    sw_limit_next = cfg_reserved_reg;
                    sw_reply_next = 1'b1;
                    grp_next      = '0;
                    before_next   = '0;
                    managed_old_next = 1'b0;
                end
            end
            pfarc_pkg::S_DECODE: begin
                idx_old_next     = dec_idx;
                managed_old_next = dec_managed;
                cnt_addr         = dec_idx;
                res_word_next    = '0;
                res_status_next  = pfarc_pkg::STS_OUT_OF_RANGE;
            end
            pfarc_pkg::S_COUNT: begin
                before_next   = cnt_rdata_reg;
                res_word_next = '0;
                if (op_reg == pfarc_pkg::OP_FREE) begin
                    if (cnt_rdata_reg == 8'd0) begin
                        res_status_next = pfarc_pkg::STS_ALREADY_FREE;
                    end else begin
                        cnt_we          = 1'b1;
                        cnt_wdata       = cnt_rdata_reg - 8'd1;
                        res_status_next = pfarc_pkg::STS_OK;
                    end
                end else if (cnt_rdata_reg == 8'd1) begin
                    res_word_next   = word_reg | pfarc_pkg::WRITABLE_BIT;
                    res_status_next = pfarc_pkg::STS_WRITABLE;
                end
            end
            pfarc_pkg::S_CLEAR: begin
                // The page just went free, so its row can no longer be full.
                bmp_we             = 1'b1;
                full_next[old_row] = 1'b0;
            end
            pfarc_pkg::S_FIND: begin
                bmp_addr        = find_row;
                pick_row_next   = find_row;
                grp_next        = grp_reg + GRP_AW'(1);
                res_word_next   = '0;
                res_status_next = pfarc_pkg::STS_NO_FREE;
            end
            pfarc_pkg::S_PICK: begin
                bmp_addr = pick_row_reg;
                if (pick_ok) begin
                    cnt_we                  = 1'b1;
                    cnt_addr                = IDX_AW'(pick_idx32);
                    cnt_wdata               = 8'd1;
                    bmp_we                  = 1'b1;
                    bmp_wdata               = pick_row_val;
                    full_next[pick_row_reg] = &pick_row_val;
                    res_status_next         = pfarc_pkg::STS_OK;
                    res_word_next = (op_reg == pfarc_pkg::OP_COW)
                                  ? (pick_addr | pfarc_pkg::NEW_PAGE_FLAGS) : pick_addr;
                end else begin
                    res_word_next   = '0;
                    res_status_next = pfarc_pkg::STS_NO_FREE;
                end
            end
            pfarc_pkg::S_DEC: begin
                cnt_we = 1'b1;
            end
            pfarc_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.result_word = res_word_reg;
                    m_data_next.status      = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_addr];
    end

    always_ff @(posedge aclk) begin
        if (bmp_we) begin
            bmp_mem[bmp_addr] <= bmp_wdata;
        end
        bmp_rdata_reg <= bmp_mem[bmp_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_reg     <= pfarc_pkg::BASE_RESET;
            cfg_total_reg    <= pfarc_pkg::TOTAL_RESET;
            cfg_reserved_reg <= pfarc_pkg::RESERVED_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                pfarc_pkg::CFG_BASE:     cfg_base_reg     <= cfg_data;
                pfarc_pkg::CFG_TOTAL:    cfg_total_reg    <= cfg_data[10:0];
                pfarc_pkg::CFG_RESERVED: cfg_reserved_reg <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset runs the initialize sweep with no reserved pages and no reply.
            state_reg    <= pfarc_pkg::S_SWEEP;
            sw_reg       <= '0;
            sw_limit_reg <= '0;
            sw_reply_reg <= 1'b0;
            grp_reg      <= '0;
            full_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sw_reg       <= sw_next;
            sw_limit_reg <= sw_limit_next;
            sw_reply_reg <= sw_reply_next;
            grp_reg      <= grp_next;
            full_reg     <= full_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        word_reg        <= word_next;
        before_reg      <= before_next;
        idx_old_reg     <= idx_old_next;
        managed_old_reg <= managed_old_next;
        pick_row_reg    <= pick_row_next;
        res_word_reg    <= res_word_next;
        res_status_reg  <= res_status_next;
        m_data_reg      <= m_data_next;
    end

endmodule
